/* rtl/core/gfr_pkg.sv */
// Package: shared types, widths and helpers for the fraction reducer.
package gfr_pkg;

   localparam int DataW = 32;
   localparam int ShiftW = $clog2(DataW);
   localparam int CntW = $clog2(DataW + 1);

   typedef struct packed {
      logic signed [DataW-1:0] numerator;
      logic signed [DataW-1:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] reduced_numerator;
      logic signed [DataW-1:0] reduced_denominator;
      logic [DataW-1:0]        common_factor;
      logic                    invalid;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic scale;
      logic div_init;
      logic div_sel_den;
      logic div_step;
      logic store_num;
      logic store_den;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic g_zero;
   } status_type;

   function automatic logic [DataW-1:0] mag_of(input logic [DataW-1:0] v);
      return v[DataW-1] ? (~v + DataW'(1)) : v;
   endfunction

endpackage

/* rtl/core/gfr_datapath.sv */
// Datapath: binary GCD step unit, shared restoring divider, result register.
module gfr_datapath (
   input  logic                clock,
   input  gfr_pkg::req_type    req_data,
   input  gfr_pkg::cmd_type    cmd,
   output gfr_pkg::status_type status,
   output gfr_pkg::rsp_type    rsp_data
);

   localparam int W = gfr_pkg::DataW;

   logic [W-1:0]              num_ff, num_in, den_ff, den_in;
   logic [W-1:0]              a_ff, a_in, b_ff, b_in;
   logic [gfr_pkg::ShiftW-1:0] k_ff, k_in;
   logic [W-1:0]              g_ff, g_in;
   logic [W-1:0]              rem_ff, rem_in, quo_ff, quo_in;
   logic [gfr_pkg::CntW-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]              qn_ff, qn_in, qd_ff, qd_in;
   gfr_pkg::rsp_type          out_ff, out_in;

   logic [W:0]   shifted, trial;
   logic [W-1:0] a_minus_b, b_minus_a;

   assign shifted   = {rem_ff, quo_ff[W-1]};
   assign trial     = shifted - {1'b0, g_ff};
   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      out_in = out_ff;

      if (cmd.load) begin
         num_in = req_data.numerator;
         den_in = req_data.denominator;
         a_in   = gfr_pkg::mag_of(req_data.numerator);
         b_in   = gfr_pkg::mag_of(req_data.denominator);
         k_in   = '0;
      end

      if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + gfr_pkg::ShiftW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_minus_b >> 1;
         end else begin
            b_in = b_minus_a >> 1;
         end
      end

      if (cmd.scale) begin
         g_in = (a_ff | b_ff) << k_ff;
      end

      if (cmd.div_init) begin
         quo_in = cmd.div_sel_den ? gfr_pkg::mag_of(den_ff) : gfr_pkg::mag_of(num_ff);
         rem_in = '0;
         cnt_in = gfr_pkg::CntW'(W);
      end else if (cmd.div_step) begin
         rem_in = trial[W] ? shifted[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff - gfr_pkg::CntW'(1);
      end

      if (cmd.store_num) begin
         qn_in = num_ff[W-1] ? (~quo_ff + W'(1)) : quo_ff;
      end
      if (cmd.store_den) begin
         qd_in = den_ff[W-1] ? (~quo_ff + W'(1)) : quo_ff;
      end

      if (cmd.out_load) begin
         if (g_ff == '0) begin
            out_in.reduced_numerator   = num_ff;
            out_in.reduced_denominator = den_ff;
            out_in.common_factor       = '0;
            out_in.invalid             = 1'b1;
         end else begin
            out_in.reduced_numerator   = qn_ff;
            out_in.reduced_denominator = qd_ff;
            out_in.common_factor       = g_ff;
            out_in.invalid             = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      out_ff <= out_in;
   end

   assign status.gcd_done = (a_ff == '0) || (b_ff == '0);
   assign status.div_done = (cnt_ff == '0);
   assign status.g_zero   = (g_ff == '0);
   assign rsp_data        = out_ff;

endmodule

/* rtl/core/gfr_ctrl.sv */
// Controller: load, GCD, scaling, two divisions (none for zero factor), result hand-off.
module gfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gfr_pkg::status_type status,
   output gfr_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      GCD,
      CHECK,
      DIV_NUM,
      DIV_DEN,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = GCD;
            end
         end
         GCD: begin
            if (status.gcd_done) begin
               cmd.scale = 1'b1;
               state_in  = CHECK;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         CHECK: begin
            if (status.g_zero) begin
               state_in = FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = DIV_NUM;
            end
         end
         DIV_NUM: begin
            if (status.div_done) begin
               cmd.store_num   = 1'b1;
               cmd.div_init    = 1'b1;
               cmd.div_sel_den = 1'b1;
               state_in        = DIV_DEN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         DIV_DEN: begin
            if (status.div_done) begin
               cmd.store_den = 1'b1;
               state_in      = FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/gcd_fraction_reducer_core.sv */
// Top level: reduces a signed fraction by the greatest common factor of its terms.
// Sequence: load, binary GCD steps, scale, check, one division per term, then
//   hand-off; both divisions are skipped when both terms are zero.
// Throughput: one item at a time; the next is taken once the result is registered,
//   set by the single-step GCD loop and the shared bit-serial divider.
// Reset: synchronous, active high; clears the sequencer and the result valid.
module gcd_fraction_reducer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gfr_pkg::rsp_type rsp_data
);

   gfr_pkg::cmd_type    cmd;
   gfr_pkg::status_type status;

   gfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gfr_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again while an item is in flight");

   a_invalid_iff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.invalid == (rsp_data.common_factor == '0)))
      else $error("invalid flag disagrees with zero factor");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in flight");

endmodule
